### hw/rtl/trc_pkg.sv
// ----------------------------------------------------------------------------
// Thermostat relay controller package
// Shared codes, widths and helpers for the thermostat relay controller.
// ----------------------------------------------------------------------------
package trc_pkg;

  localparam int TEMP_W     = 12;
  localparam int HYST_W     = 7;
  localparam int TARGET_W   = 7;
  localparam int FAN_CNT_W  = 12;
  localparam int AC_CNT_W   = 5;
  localparam int CFG_IDX_W  = 8;
  localparam int CMP_W      = 13;

  localparam logic [FAN_CNT_W-1:0] FAN_CYCLE_ON_SEC  = 12'd900;
  localparam logic [FAN_CNT_W-1:0] FAN_CYCLE_OFF_SEC = 12'd2700;
  localparam logic [AC_CNT_W-1:0]  AC_RECHECK_SEC    = 5'd30;
  localparam logic [FAN_CNT_W-1:0] FAN_CHANGE_DELAY  = 12'd5;
  localparam logic [AC_CNT_W-1:0]  AC_CHANGE_DELAY   = 5'd30;

  localparam logic [7:0] SETPOINT_MIN = 8'd60;
  localparam logic [7:0] SETPOINT_MAX = 8'd90;

  localparam logic [TARGET_W-1:0] COOL_TARGET_RST = 7'd75;
  localparam logic [TARGET_W-1:0] HEAT_TARGET_RST = 7'd68;
  localparam logic [HYST_W-1:0]   HYST_RST        = 7'd10;

  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_FAN   = 3'd1;
  localparam logic [2:0] REQ_AC    = 3'd2;
  localparam logic [2:0] REQ_COOL  = 3'd3;
  localparam logic [2:0] REQ_HEAT  = 3'd4;

  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_FIRST  = 2'd1;
  localparam logic [1:0] MODE_SECOND = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HYST_RELEASE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST_TRIGGER = 8'd1;

  localparam int OFF_FAN  = 0;
  localparam int OFF_COOL = 1;
  localparam int OFF_HEAT = 2;

  typedef logic [2:0] relay_off_t;

  function automatic logic [1:0] mode_decode(input logic [7:0] val);
    mode_decode = (val > 8'(MODE_SECOND)) ? MODE_OFF : val[1:0];
  endfunction

  function automatic logic [TARGET_W-1:0] clamp_setpoint(input logic [7:0] val);
    logic [7:0] c;
    c = val;
    if (val < SETPOINT_MIN) c = SETPOINT_MIN;
    if (val > SETPOINT_MAX) c = SETPOINT_MAX;
    clamp_setpoint = c[TARGET_W-1:0];
  endfunction

endpackage

### hw/rtl/thermostat_relay_controller.sv
// ----------------------------------------------------------------------------
// Thermostat relay controller
// Fan and A/C relay control with setpoint hysteresis, driven by tick and command words.
// ----------------------------------------------------------------------------
// Takes one word per clock while in_ready is high and returns its result word
// from one result register loaded on acceptance. in_ready is high when that
// register is empty or its word is being taken, so a result word left waiting
// holds the input off until it is taken. All state updates and relay decisions
// are done in one pass of compare-and-count logic ahead of the result
// register. Configuration writes are always accepted (cfg_ready is tied high).
// ----------------------------------------------------------------------------
module thermostat_relay_controller
  import trc_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  req_type,
  input  logic [7:0]                  cmd_value,
  input  logic signed [TEMP_W-1:0]    temp_tenths_f,
  input  logic                        temp_ok,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        fan_on,
  output logic                        cool_on,
  output logic                        heat_on,
  output logic                        master_on,
  output logic                        relays_changed,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [HYST_W-1:0]           cfg_data
);

  logic [HYST_W-1:0]    rel_band;
  logic [HYST_W-1:0]    trg_band;
  relay_off_t           relay_off;
  relay_off_t           relay_off_next;
  logic [FAN_CNT_W-1:0] fan_cnt;
  logic [FAN_CNT_W-1:0] fan_cnt_next;
  logic [AC_CNT_W-1:0]  ac_cnt;
  logic [AC_CNT_W-1:0]  ac_cnt_next;
  logic [1:0]           fan_setting;
  logic [1:0]           fan_setting_next;
  logic [1:0]           ac_mode;
  logic [1:0]           ac_mode_next;
  logic [TARGET_W-1:0]  cool_target;
  logic [TARGET_W-1:0]  cool_target_next;
  logic [TARGET_W-1:0]  heat_target;
  logic [TARGET_W-1:0]  heat_target_next;

  logic                 in_accept;
  logic signed [CMP_W-1:0] temp_x;
  logic signed [CMP_W-1:0] cool_sp;
  logic signed [CMP_W-1:0] heat_sp;
  logic signed [CMP_W-1:0] rel_x;
  logic signed [CMP_W-1:0] trg_x;
  logic                 out_fan;
  logic                 out_cool;
  logic                 out_heat;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign temp_x  = CMP_W'(temp_tenths_f);
  assign cool_sp = $signed({2'b00, 11'(cool_target) * 11'd10});
  assign heat_sp = $signed({2'b00, 11'(heat_target) * 11'd10});
  assign rel_x   = $signed({6'd0, rel_band});
  assign trg_x   = $signed({6'd0, trg_band});

  always_comb begin
    relay_off_next   = relay_off;
    fan_cnt_next     = fan_cnt;
    ac_cnt_next      = ac_cnt;
    fan_setting_next = fan_setting;
    ac_mode_next     = ac_mode;
    cool_target_next = cool_target;
    heat_target_next = heat_target;
    case (req_type)
      REQ_TICK: begin
        if (fan_cnt != '0) begin
          fan_cnt_next = fan_cnt - 1'b1;
          if (fan_cnt_next == '0) begin
            case (fan_setting)
              MODE_FIRST:  relay_off_next[OFF_FAN] = 1'b0;
              MODE_SECOND: begin
                if (relay_off[OFF_FAN]) begin
                  relay_off_next[OFF_FAN] = 1'b0;
                  fan_cnt_next = FAN_CYCLE_ON_SEC;
                end else begin
                  relay_off_next[OFF_FAN] = 1'b1;
                  fan_cnt_next = FAN_CYCLE_OFF_SEC;
                end
              end
              default:     relay_off_next[OFF_FAN] = 1'b1;
            endcase
          end
        end
        if (ac_cnt != '0 && temp_ok) begin
          ac_cnt_next = ac_cnt - 1'b1;
          if (ac_cnt_next == '0) begin
            case (ac_mode)
              MODE_FIRST: begin
                if (!relay_off[OFF_COOL] && temp_x < cool_sp - rel_x)
                  relay_off_next[OFF_COOL] = 1'b1;
                if (relay_off[OFF_COOL] && temp_x > cool_sp + trg_x)
                  relay_off_next[OFF_COOL] = 1'b0;
              end
              MODE_SECOND: begin
                if (!relay_off[OFF_HEAT] && temp_x > heat_sp + rel_x)
                  relay_off_next[OFF_HEAT] = 1'b1;
                if (relay_off[OFF_HEAT] && temp_x < heat_sp - trg_x)
                  relay_off_next[OFF_HEAT] = 1'b0;
              end
              default: begin
                relay_off_next[OFF_COOL] = 1'b1;
                relay_off_next[OFF_HEAT] = 1'b1;
              end
            endcase
            ac_cnt_next = AC_RECHECK_SEC;
          end
        end
        // drop both when cool and heat would run together
        if (!relay_off_next[OFF_COOL] && !relay_off_next[OFF_HEAT]) begin
          relay_off_next[OFF_COOL] = 1'b1;
          relay_off_next[OFF_HEAT] = 1'b1;
        end
      end
      REQ_FAN: begin
        fan_setting_next = mode_decode(cmd_value);
        fan_cnt_next     = FAN_CHANGE_DELAY;
      end
      REQ_AC: begin
        ac_mode_next = mode_decode(cmd_value);
        ac_cnt_next  = AC_CHANGE_DELAY;
      end
      REQ_COOL: begin
        cool_target_next = clamp_setpoint(cmd_value);
        ac_cnt_next      = AC_CHANGE_DELAY;
      end
      REQ_HEAT: begin
        heat_target_next = clamp_setpoint(cmd_value);
        ac_cnt_next      = AC_CHANGE_DELAY;
      end
      default: ;
    endcase
  end

  assign out_cool = !relay_off_next[OFF_COOL];
  assign out_heat = !relay_off_next[OFF_HEAT];
  assign out_fan  = !relay_off_next[OFF_FAN] || out_cool || out_heat;

  always_ff @(posedge clk) begin
    if (rst) begin
      rel_band <= HYST_RST;
      trg_band <= HYST_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_HYST_RELEASE) rel_band <= cfg_data;
      if (cfg_index == CFG_HYST_TRIGGER) trg_band <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      relay_off   <= 3'b111;
      fan_cnt     <= '0;
      ac_cnt      <= '0;
      fan_setting <= MODE_OFF;
      ac_mode     <= MODE_OFF;
      cool_target <= COOL_TARGET_RST;
      heat_target <= HEAT_TARGET_RST;
    end else if (in_accept) begin
      relay_off   <= relay_off_next;
      fan_cnt     <= fan_cnt_next;
      ac_cnt      <= ac_cnt_next;
      fan_setting <= fan_setting_next;
      ac_mode     <= ac_mode_next;
      cool_target <= cool_target_next;
      heat_target <= heat_target_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      fan_on         <= out_fan;
      cool_on        <= out_cool;
      heat_on        <= out_heat;
      master_on      <= out_fan;
      relays_changed <= (relay_off_next != relay_off);
    end
  end

`ifndef ASSERT_OFF
  a_no_cool_and_heat: assert property (@(posedge clk) disable iff (rst)
    relay_off[OFF_COOL] || relay_off[OFF_HEAT])
    else $error("cool and heat relays both on");

  a_cmd_keeps_relays: assert property (@(posedge clk) disable iff (rst)
    in_accept && req_type != REQ_TICK |=> $stable(relay_off))
    else $error("command word changed relay state");

  a_ac_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    ac_cnt <= AC_CHANGE_DELAY)
    else $error("ac countdown out of range");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted word produced no result");

  a_master_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && (cool_on || heat_on) |-> fan_on && master_on)
    else $error("fan or master off while compressor runs");
`endif

endmodule
